[rtl/opd_pkg.sv]
// ----------------------------------------------------------------------------
// opd_pkg
// Shared constants, types and face tables for the orientation packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ROLL   = 3'd1;
  localparam logic [2:0] EV_STABLE = 3'd2;
  localparam logic [2:0] EV_CHARGE = 3'd3;
  localparam logic [2:0] EV_CHRG   = 3'd4;
  localparam logic [2:0] EV_COLOR  = 3'd5;

  localparam logic [0:0] REG_PRESENT = 1'd0;
  localparam logic [0:0] REG_ENABLE  = 1'd1;

  localparam logic [2:0] SHAPE_NONE = 3'd0;
  localparam logic [2:0] SHAPE_D4   = 3'd1;
  localparam logic [2:0] SHAPE_D6   = 3'd2;
  localparam logic [2:0] SHAPE_D8   = 3'd3;
  localparam logic [2:0] SHAPE_D10  = 3'd4;
  localparam logic [2:0] SHAPE_D12  = 3'd5;
  localparam logic [2:0] SHAPE_D20  = 3'd6;
  localparam logic [2:0] SHAPE_D100 = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] event_kind;
    logic [7:0] die_echo;
    logic [6:0] event_value;
    logic       stable;
    logic [2:0] shape;
    logic [7:0] ax;
    logic [7:0] ay;
    logic [7:0] az;
  } cls_t;

  function automatic logic [23:0] cube_face(input logic [2:0] i);
    case (i)
      3'd0: cube_face = {8'd192, 8'd0, 8'd0};
      3'd1: cube_face = {8'd0, 8'd0, 8'd64};
      3'd2: cube_face = {8'd0, 8'd64, 8'd0};
      3'd3: cube_face = {8'd0, 8'd192, 8'd0};
      3'd4: cube_face = {8'd0, 8'd0, 8'd192};
      default: cube_face = {8'd64, 8'd0, 8'd0};
    endcase
  endfunction

  function automatic logic [23:0] ico_face(input logic [4:0] i);
    case (i)
      5'd0:  ico_face = {-8'sd64, 8'sd0, -8'sd22};
      5'd1:  ico_face = {8'sd42, -8'sd42, 8'sd40};
      5'd2:  ico_face = {8'sd0, 8'sd22, -8'sd64};
      5'd3:  ico_face = {8'sd0, 8'sd22, 8'sd64};
      5'd4:  ico_face = {-8'sd42, -8'sd42, 8'sd42};
      5'd5:  ico_face = {8'sd22, 8'sd64, 8'sd0};
      5'd6:  ico_face = {-8'sd42, -8'sd42, -8'sd42};
      5'd7:  ico_face = {8'sd64, 8'sd0, -8'sd22};
      5'd8:  ico_face = {-8'sd22, 8'sd64, 8'sd0};
      5'd9:  ico_face = {8'sd42, -8'sd42, -8'sd42};
      5'd10: ico_face = {-8'sd42, 8'sd42, 8'sd42};
      5'd11: ico_face = {8'sd22, -8'sd64, 8'sd0};
      5'd12: ico_face = {-8'sd64, 8'sd0, 8'sd22};
      5'd13: ico_face = {8'sd42, 8'sd42, 8'sd42};
      5'd14: ico_face = {-8'sd22, -8'sd64, 8'sd0};
      5'd15: ico_face = {8'sd42, 8'sd42, -8'sd42};
      5'd16: ico_face = {8'sd0, -8'sd22, -8'sd64};
      5'd17: ico_face = {8'sd0, -8'sd22, 8'sd64};
      5'd18: ico_face = {-8'sd42, 8'sd42, -8'sd42};
      default: ico_face = {8'sd64, 8'sd0, 8'sd22};
    endcase
  endfunction

  function automatic logic [23:0] tri_face(input logic [4:0] i);
    case (i)
      5'd0:  tri_face = {8'sd20, -8'sd60, -8'sd20};
      5'd1:  tri_face = {8'sd20, 8'sd0, 8'sd60};
      5'd2:  tri_face = {-8'sd40, -8'sd40, 8'sd40};
      5'd3:  tri_face = {-8'sd60, 8'sd0, 8'sd20};
      5'd4:  tri_face = {8'sd40, 8'sd20, 8'sd40};
      5'd5:  tri_face = {-8'sd20, -8'sd60, -8'sd20};
      5'd6:  tri_face = {8'sd20, 8'sd60, 8'sd20};
      5'd7:  tri_face = {-8'sd40, 8'sd20, -8'sd40};
      5'd8:  tri_face = {-8'sd40, 8'sd40, 8'sd40};
      5'd9:  tri_face = {-8'sd20, 8'sd0, 8'sd60};
      5'd10: tri_face = {-8'sd20, -8'sd60, 8'sd20};
      5'd11: tri_face = {8'sd60, 8'sd0, 8'sd20};
      5'd12: tri_face = {-8'sd60, 8'sd0, -8'sd20};
      5'd13: tri_face = {8'sd20, 8'sd60, -8'sd20};
      5'd14: tri_face = {8'sd20, 8'sd0, -8'sd60};
      5'd15: tri_face = {8'sd40, -8'sd20, -8'sd40};
      5'd16: tri_face = {-8'sd20, 8'sd60, -8'sd20};
      5'd17: tri_face = {-8'sd40, -8'sd40, -8'sd40};
      5'd18: tri_face = {8'sd40, -8'sd20, 8'sd40};
      5'd19: tri_face = {8'sd20, -8'sd60, 8'sd20};
      5'd20: tri_face = {8'sd60, 8'sd0, -8'sd20};
      5'd21: tri_face = {8'sd40, 8'sd20, -8'sd40};
      5'd22: tri_face = {-8'sd20, 8'sd0, -8'sd60};
      default: tri_face = {-8'sd20, 8'sd60, 8'sd20};
    endcase
  endfunction

  function automatic logic [2:0] map_d4(input logic [4:0] i);
    case (i)
      5'd0: map_d4 = 3'd3;  5'd1: map_d4 = 3'd1;  5'd2: map_d4 = 3'd4;
      5'd3: map_d4 = 3'd1;  5'd4: map_d4 = 3'd4;  5'd5: map_d4 = 3'd4;
      5'd6: map_d4 = 3'd1;  5'd7: map_d4 = 3'd4;  5'd8: map_d4 = 3'd2;
      5'd9: map_d4 = 3'd3;  5'd10: map_d4 = 3'd1; 5'd11: map_d4 = 3'd1;
      5'd12: map_d4 = 3'd1; 5'd13: map_d4 = 3'd4; 5'd14: map_d4 = 3'd2;
      5'd15: map_d4 = 3'd3; 5'd16: map_d4 = 3'd3; 5'd17: map_d4 = 3'd2;
      5'd18: map_d4 = 3'd2; 5'd19: map_d4 = 3'd2; 5'd20: map_d4 = 3'd4;
      5'd21: map_d4 = 3'd1; 5'd22: map_d4 = 3'd3;
      default: map_d4 = 3'd2;
    endcase
  endfunction

  function automatic logic [3:0] map_d8(input logic [4:0] i);
    case (i)
      5'd0: map_d8 = 4'd3;  5'd1: map_d8 = 4'd3;  5'd2: map_d8 = 4'd6;
      5'd3: map_d8 = 4'd1;  5'd4: map_d8 = 4'd2;  5'd5: map_d8 = 4'd8;
      5'd6: map_d8 = 4'd1;  5'd7: map_d8 = 4'd1;  5'd8: map_d8 = 4'd4;
      5'd9: map_d8 = 4'd7;  5'd10: map_d8 = 4'd5; 5'd11: map_d8 = 4'd5;
      5'd12: map_d8 = 4'd4; 5'd13: map_d8 = 4'd4; 5'd14: map_d8 = 4'd2;
      5'd15: map_d8 = 4'd5; 5'd16: map_d8 = 4'd7; 5'd17: map_d8 = 4'd7;
      5'd18: map_d8 = 4'd8; 5'd19: map_d8 = 4'd2; 5'd20: map_d8 = 4'd8;
      5'd21: map_d8 = 4'd3; 5'd22: map_d8 = 4'd6;
      default: map_d8 = 4'd6;
    endcase
  endfunction

  function automatic logic [3:0] map_d10(input logic [4:0] i);
    case (i)
      5'd0: map_d10 = 4'd8;  5'd1: map_d10 = 4'd2;  5'd2: map_d10 = 4'd6;
      5'd3: map_d10 = 4'd1;  5'd4: map_d10 = 4'd4;  5'd5: map_d10 = 4'd3;
      5'd6: map_d10 = 4'd9;  5'd7: map_d10 = 4'd0;  5'd8: map_d10 = 4'd7;
      5'd9: map_d10 = 4'd5;  5'd10: map_d10 = 4'd5; 5'd11: map_d10 = 4'd7;
      5'd12: map_d10 = 4'd0; 5'd13: map_d10 = 4'd9; 5'd14: map_d10 = 4'd3;
      5'd15: map_d10 = 4'd4; 5'd16: map_d10 = 4'd1; 5'd17: map_d10 = 4'd6;
      5'd18: map_d10 = 4'd2;
      default: map_d10 = 4'd8;
    endcase
  endfunction

  function automatic logic [16:0] dist2(input logic [23:0] f, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] z);
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic signed [8:0] dz;
    logic [17:0] sx;
    logic [17:0] sy;
    logic [17:0] sz;
    dx = $signed({f[23], f[23:16]}) - $signed({x[7], x});
    dy = $signed({f[15], f[15:8]}) - $signed({y[7], y});
    dz = $signed({f[7], f[7:0]}) - $signed({z[7], z});
    sx = 18'(dx * dx);
    sy = 18'(dy * dy);
    sz = 18'(dz * dz);
    dist2 = 17'(sx + sy + sz);
  endfunction

endpackage

`default_nettype wire

[rtl/orientation_packet_decoder.sv]
// ----------------------------------------------------------------------------
// orientation_packet_decoder
// Decodes one die event packet per transfer into a status, kind, echo and value.
// Pipeline: two register stages (input register, then result register); a
// packet moves on when the result register is empty or out_stall is low.
// Throughput: one packet per cycle unless a stalled full result register
// raises in_stall; prefix checks and parallel face search are combinational.
// Reset clears both valid flags and sets both configuration registers to ones.
// ----------------------------------------------------------------------------
`default_nettype none

module orientation_packet_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] die_number,
  input  wire logic [6:0] die_sides,
  input  wire logic [7:0] packet_length,
  input  wire logic [7:0] byte0,
  input  wire logic [7:0] byte1,
  input  wire logic [7:0] byte2,
  input  wire logic [7:0] byte3,
  input  wire logic [7:0] byte4,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [2:0]      event_kind,
  output logic [7:0]      die_echo,
  output logic [6:0]      event_value
);

  logic          handlers_present;
  logic [4:0]    handler_enable;
  logic          mid_valid;
  opd_pkg::cls_t cls_in;
  opd_pkg::cls_t mid;
  logic [1:0]    st_c;
  logic [2:0]    ek_c;
  logic [7:0]    de_c;
  logic [6:0]    ev_c;
  logic          out_adv;
  logic          mid_adv;

  assign cfg_ready = 1'b1;
  assign out_adv = !out_valid || !out_stall;
  assign mid_adv = !mid_valid || out_adv;
  assign in_stall = !mid_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      handlers_present <= 1'b1;
      handler_enable <= 5'd31;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        opd_pkg::REG_PRESENT: handlers_present <= cfg_data[0];
        opd_pkg::REG_ENABLE:  handler_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  opd_classify u_classify (
    .handlers_present (handlers_present),
    .handler_enable   (handler_enable),
    .die_number       (die_number),
    .die_sides        (die_sides),
    .packet_length    (packet_length),
    .byte0            (byte0),
    .byte1            (byte1),
    .byte2            (byte2),
    .byte3            (byte3),
    .byte4            (byte4),
    .cls              (cls_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_adv) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && in_valid) begin
      mid <= cls_in;
    end
  end

  opd_face u_face (
    .cls         (mid),
    .status      (st_c),
    .event_kind  (ek_c),
    .die_echo    (de_c),
    .event_value (ev_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid) begin
      status <= st_c;
      event_kind <= ek_c;
      die_echo <= de_c;
      event_value <= ev_c;
    end
  end

endmodule

`default_nettype wire

[rtl/opd_classify.sv]
// ----------------------------------------------------------------------------
// opd_classify
// Prefix match, length and payload checks, handler gating for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_classify (
  input  wire logic             handlers_present,
  input  wire logic [4:0]       handler_enable,
  input  wire logic [7:0]       die_number,
  input  wire logic [6:0]       die_sides,
  input  wire logic [7:0]       packet_length,
  input  wire logic [7:0]       byte0,
  input  wire logic [7:0]       byte1,
  input  wire logic [7:0]       byte2,
  input  wire logic [7:0]       byte3,
  input  wire logic [7:0]       byte4,
  output opd_pkg::cls_t         cls
);

  logic p_r, p_tap, p_dtap, p_bat, p_char, p_s, p_xs, p_col;
  logic [2:0] shape;

  always_comb begin
    p_r    = packet_length >= 8'd1 && byte0 == "R";
    p_tap  = packet_length >= 8'd3 && byte0 == "T" && byte1 == "a" && byte2 == "p";
    p_dtap = packet_length >= 8'd4 && byte0 == "D" && byte1 == "T" && byte2 == "a"
             && byte3 == "p";
    p_bat  = packet_length >= 8'd3 && byte0 == "B" && byte1 == "a" && byte2 == "t";
    p_char = packet_length >= 8'd4 && byte0 == "C" && byte1 == "h" && byte2 == "a"
             && byte3 == "r";
    p_s    = packet_length >= 8'd1 && byte0 == "S";
    p_xs   = packet_length >= 8'd2 && byte1 == "S"
             && (byte0 == "F" || byte0 == "T" || byte0 == "M");
    p_col  = packet_length >= 8'd3 && byte0 == "C" && byte1 == "o" && byte2 == "l";
  end

  always_comb begin
    case (die_sides)
      7'd4:   shape = opd_pkg::SHAPE_D4;
      7'd6:   shape = opd_pkg::SHAPE_D6;
      7'd8:   shape = opd_pkg::SHAPE_D8;
      7'd10:  shape = opd_pkg::SHAPE_D10;
      7'd12:  shape = opd_pkg::SHAPE_D12;
      7'd20:  shape = opd_pkg::SHAPE_D20;
      7'd100: shape = opd_pkg::SHAPE_D100;
      default: shape = opd_pkg::SHAPE_NONE;
    endcase
  end

  always_comb begin
    cls = '0;
    cls.die_echo = die_number;
    cls.shape = shape;
    if (p_s) begin
      cls.ax = byte1; cls.ay = byte2; cls.az = byte3;
    end else begin
      cls.ax = byte2; cls.ay = byte3; cls.az = byte4;
    end
    if (!handlers_present) begin
      cls.status = opd_pkg::ST_MISSING;
    end else if (p_r) begin
      cls.event_kind = opd_pkg::EV_ROLL;
      cls.status = handler_enable[0] ? opd_pkg::ST_OK : opd_pkg::ST_MISSING;
    end else if (p_tap || p_dtap) begin
      cls.status = opd_pkg::ST_OK;
    end else if (p_bat) begin
      cls.event_kind = opd_pkg::EV_CHARGE;
      if (!handler_enable[2]) cls.status = opd_pkg::ST_MISSING;
      else if (packet_length != 8'd4 || byte3 > 8'd100) cls.status = opd_pkg::ST_INVALID;
      else cls.event_value = byte3[6:0];
    end else if (p_char) begin
      cls.event_kind = opd_pkg::EV_CHRG;
      if (!handler_enable[3]) cls.status = opd_pkg::ST_MISSING;
      else if (packet_length != 8'd5 || byte4 > 8'd1) cls.status = opd_pkg::ST_INVALID;
      else cls.event_value = byte4[6:0];
    end else if (p_s || p_xs) begin
      cls.event_kind = opd_pkg::EV_STABLE;
      if (!handler_enable[1]) cls.status = opd_pkg::ST_MISSING;
      else if (packet_length != (p_s ? 8'd4 : 8'd5)) cls.status = opd_pkg::ST_INVALID;
      else cls.stable = 1'b1;
    end else if (p_col) begin
      cls.event_kind = opd_pkg::EV_COLOR;
      if (!handler_enable[4]) cls.status = opd_pkg::ST_MISSING;
      else if (packet_length != 8'd4 || byte3 > 8'd5) cls.status = opd_pkg::ST_INVALID;
      else cls.event_value = byte3[6:0];
    end else begin
      cls.status = opd_pkg::ST_INVALID;
    end
  end

endmodule

`default_nettype wire

[rtl/opd_face.sv]
// ----------------------------------------------------------------------------
// opd_face
// Nearest face search over the constant tables and face to value mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_face (
  input  wire opd_pkg::cls_t cls,
  output logic [1:0]         status,
  output logic [2:0]         event_kind,
  output logic [7:0]         die_echo,
  output logic [6:0]         event_value
);

  logic [16:0] d_cube [6];
  logic [16:0] d_ico  [20];
  logic [16:0] d_tri  [24];
  logic [2:0]  best_cube;
  logic [4:0]  best_ico;
  logic [4:0]  best_tri;
  logic [4:0]  tri12;
  logic [3:0]  v10;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d_cube[i] = opd_pkg::dist2(opd_pkg::cube_face(3'(i)), cls.ax, cls.ay, cls.az);
    end
    for (int i = 0; i < 20; i++) begin
      d_ico[i] = opd_pkg::dist2(opd_pkg::ico_face(5'(i)), cls.ax, cls.ay, cls.az);
    end
    for (int i = 0; i < 24; i++) begin
      d_tri[i] = opd_pkg::dist2(opd_pkg::tri_face(5'(i)), cls.ax, cls.ay, cls.az);
    end
  end

  // compare tree, the lower index wins ties so the first minimum is kept
  always_comb begin
    logic [16:0] cd [8];
    logic [2:0]  ci [8];
    logic [16:0] od [32];
    logic [4:0]  oi [32];
    logic [16:0] td [32];
    logic [4:0]  ti [32];
    for (int i = 0; i < 8; i++) begin
      cd[i] = '1;
      ci[i] = 3'(i);
    end
    for (int i = 0; i < 6; i++) begin
      cd[i] = d_cube[i];
    end
    for (int i = 0; i < 32; i++) begin
      od[i] = '1;
      oi[i] = 5'(i);
      td[i] = '1;
      ti[i] = 5'(i);
    end
    for (int i = 0; i < 20; i++) begin
      od[i] = d_ico[i];
    end
    for (int i = 0; i < 24; i++) begin
      td[i] = d_tri[i];
    end
    for (int w = 4; w > 0; w = w >> 1) begin
      for (int k = 0; k < w; k++) begin
        if (cd[2 * k + 1] < cd[2 * k]) begin
          cd[k] = cd[2 * k + 1]; ci[k] = ci[2 * k + 1];
        end else begin
          cd[k] = cd[2 * k]; ci[k] = ci[2 * k];
        end
      end
    end
    for (int w = 16; w > 0; w = w >> 1) begin
      for (int k = 0; k < w; k++) begin
        if (od[2 * k + 1] < od[2 * k]) begin
          od[k] = od[2 * k + 1]; oi[k] = oi[2 * k + 1];
        end else begin
          od[k] = od[2 * k]; oi[k] = oi[2 * k];
        end
        if (td[2 * k + 1] < td[2 * k]) begin
          td[k] = td[2 * k + 1]; ti[k] = ti[2 * k + 1];
        end else begin
          td[k] = td[2 * k]; ti[k] = ti[2 * k];
        end
      end
    end
    best_cube = ci[0];
    best_ico = oi[0];
    best_tri = ti[0];
  end

  always_comb begin
    tri12 = (best_tri >= 5'd12) ? best_tri - 5'd11 : best_tri + 5'd1;
    v10 = opd_pkg::map_d10(best_ico);
    status = cls.status;
    event_kind = cls.event_kind;
    die_echo = cls.die_echo;
    event_value = cls.event_value;
    if (cls.stable) begin
      case (cls.shape)
        opd_pkg::SHAPE_D4:   event_value = {4'd0, opd_pkg::map_d4(best_tri)};
        opd_pkg::SHAPE_D6:   event_value = 7'(best_cube) + 7'd1;
        opd_pkg::SHAPE_D8:   event_value = {3'd0, opd_pkg::map_d8(best_tri)};
        opd_pkg::SHAPE_D10:  event_value = {3'd0, v10};
        opd_pkg::SHAPE_D12:  event_value = {2'd0, tri12};
        opd_pkg::SHAPE_D20:  event_value = 7'(best_ico) + 7'd1;
        opd_pkg::SHAPE_D100: event_value = 7'({3'd0, v10} * 7'd10);
        default: begin
          event_kind = opd_pkg::EV_NONE;
          event_value = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/orientation_packet_decoder_checker.sv]
// ----------------------------------------------------------------------------
// orientation_packet_decoder_checker
// Watches the packet and result channels and the register write port, works
// out the expected status, kind, echo and value of every accepted packet, and
// compares each result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orientation_packet_decoder_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] die_number,
  input  wire logic [6:0] die_sides,
  input  wire logic [7:0] packet_length,
  input  wire logic [7:0] byte0,
  input  wire logic [7:0] byte1,
  input  wire logic [7:0] byte2,
  input  wire logic [7:0] byte3,
  input  wire logic [7:0] byte4,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] status,
  input  wire logic [2:0] event_kind,
  input  wire logic [7:0] die_echo,
  input  wire logic [6:0] event_value,
  output int              error_count,
  output int              pending_count
);

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] kind;
    logic [7:0] echo;
    logic [6:0] value;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic       present_reg;
  logic [4:0] enable_reg;

  localparam byte TRI_X[24] = '{20, 20, -40, -60, 40, -20, 20, -40, -40, -20, -20, 60,
                                -60, 20, 20, 40, -20, -40, 40, 20, 60, 40, -20, -20};
  localparam byte TRI_Y[24] = '{-60, 0, -40, 0, 20, -60, 60, 20, 40, 0, -60, 0,
                                0, 60, 0, -20, 60, -40, -20, -60, 0, 20, 0, 60};
  localparam byte TRI_Z[24] = '{-20, 60, 40, 20, 40, -20, 20, -40, 40, 60, 20, 20,
                                -20, -20, -60, -40, -20, -40, 40, 20, -20, -40, -60, 20};
  localparam byte ICO_X[20] = '{-64, 42, 0, 0, -42, 22, -42, 64, -22, 42,
                                -42, 22, -64, 42, -22, 42, 0, 0, -42, 64};
  localparam byte ICO_Y[20] = '{0, -42, 22, 22, -42, 64, -42, 0, 64, -42,
                                42, -64, 0, 42, -64, 42, -22, -22, 42, 0};
  localparam byte ICO_Z[20] = '{-22, 40, -64, 64, 42, 0, -42, -22, 0, -42,
                                42, 0, 22, 42, 0, -42, -64, 64, -42, 22};
  localparam byte CUBE_X[6] = '{-64, 0, 0, 0, 0, 64};
  localparam byte CUBE_Y[6] = '{0, 0, 64, -64, 0, 0};
  localparam byte CUBE_Z[6] = '{0, 64, 0, 0, -64, 0};
  localparam byte D4_FACE[24] = '{3, 1, 4, 1, 4, 4, 1, 4, 2, 3, 1, 1,
                                  1, 4, 2, 3, 3, 2, 2, 2, 4, 1, 3, 2};
  localparam byte D8_FACE[24] = '{3, 3, 6, 1, 2, 8, 1, 1, 4, 7, 5, 5,
                                  4, 4, 2, 5, 7, 7, 8, 2, 8, 3, 6, 6};
  localparam byte D10_FACE[20] = '{8, 2, 6, 1, 4, 3, 9, 0, 7, 5,
                                   5, 7, 0, 9, 3, 4, 1, 6, 2, 8};

  // zero-based index of nearest face, first minimum wins
  function automatic int nearest(input int shape, input int ax, input int ay, input int az);
    int n, d, best, best_d, fx, fy, fz;
    n = (shape == 6) ? 6 : (shape == 20) ? 20 : 24;
    best = 0;
    best_d = 32'h7fffffff;
    for (int i = 0; i < n; i++) begin
      if (shape == 6) begin
        fx = CUBE_X[i]; fy = CUBE_Y[i]; fz = CUBE_Z[i];
      end else if (shape == 20) begin
        fx = ICO_X[i]; fy = ICO_Y[i]; fz = ICO_Z[i];
      end else begin
        fx = TRI_X[i]; fy = TRI_Y[i]; fz = TRI_Z[i];
      end
      d = (fx - ax) * (fx - ax) + (fy - ay) * (fy - ay) + (fz - az) * (fz - az);
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic decoded_t decode_packet(input logic [7:0] len, input logic [6:0] sides,
                                             input logic [7:0] id, input logic [7:0] b[5]);
    decoded_t r;
    int off, ax, ay, az, f;
    r = '0;
    r.echo = id;
    if (!present_reg) begin
      r.status = opd_pkg::ST_MISSING;
    end else if (len >= 1 && b[0] == "R") begin
      r.kind = opd_pkg::EV_ROLL;
      r.status = enable_reg[0] ? opd_pkg::ST_OK : opd_pkg::ST_MISSING;
    end else if ((len >= 3 && b[0] == "T" && b[1] == "a" && b[2] == "p") ||
                 (len >= 4 && b[0] == "D" && b[1] == "T" && b[2] == "a" && b[3] == "p")) begin
      r.status = opd_pkg::ST_OK;
    end else if (len >= 3 && b[0] == "B" && b[1] == "a" && b[2] == "t") begin
      r.kind = opd_pkg::EV_CHARGE;
      if (!enable_reg[2]) r.status = opd_pkg::ST_MISSING;
      else if (len != 4 || b[3] > 100) r.status = opd_pkg::ST_INVALID;
      else r.value = b[3][6:0];
    end else if (len >= 4 && b[0] == "C" && b[1] == "h" && b[2] == "a" && b[3] == "r") begin
      r.kind = opd_pkg::EV_CHRG;
      if (!enable_reg[3]) r.status = opd_pkg::ST_MISSING;
      else if (len != 5 || b[4] > 1) r.status = opd_pkg::ST_INVALID;
      else r.value = b[4][6:0];
    end else if ((len >= 1 && b[0] == "S") ||
                 (len >= 2 && b[1] == "S" && (b[0] == "F" || b[0] == "T" || b[0] == "M"))) begin
      off = (b[0] == "S") ? 1 : 2;
      r.kind = opd_pkg::EV_STABLE;
      if (!enable_reg[1]) begin
        r.status = opd_pkg::ST_MISSING;
      end else if (len != off + 3) begin
        r.status = opd_pkg::ST_INVALID;
      end else begin
        ax = $signed(b[off]);
        ay = $signed(b[off + 1]);
        az = $signed(b[off + 2]);
        case (sides)
          4:   r.value = 7'(D4_FACE[nearest(24, ax, ay, az)]);
          6:   r.value = 7'(nearest(6, ax, ay, az) + 1);
          8:   r.value = 7'(D8_FACE[nearest(24, ax, ay, az)]);
          10:  r.value = 7'(D10_FACE[nearest(20, ax, ay, az)]);
          12: begin
            f = nearest(24, ax, ay, az) + 1;
            r.value = 7'((f > 12) ? f - 12 : f);
          end
          20:  r.value = 7'(nearest(20, ax, ay, az) + 1);
          100: r.value = 7'(10 * D10_FACE[nearest(20, ax, ay, az)]);
          default: r.kind = opd_pkg::EV_NONE;
        endcase
      end
    end else if (len >= 3 && b[0] == "C" && b[1] == "o" && b[2] == "l") begin
      r.kind = opd_pkg::EV_COLOR;
      if (!enable_reg[4]) r.status = opd_pkg::ST_MISSING;
      else if (len != 4 || b[3] > 5) r.status = opd_pkg::ST_INVALID;
      else r.value = b[3][6:0];
    end else begin
      r.status = opd_pkg::ST_INVALID;
    end
    return r;
  endfunction

  assign pending_count = decoded_q.size();

  always @(posedge clk) begin
    decoded_t exp_r;
    logic [7:0] pkt[5];
    if (rst) begin
      present_reg <= 1'b1;
      enable_reg <= 5'h1f;
      error_count <= 0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pkt = '{byte0, byte1, byte2, byte3, byte4};
        decoded_q.push_back(decode_packet(packet_length, die_sides, die_number, pkt));
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected: actual %h/%h/%h/%h", $time,
                   status, event_kind, die_echo, event_value);
          error_count <= error_count + 1;
        end else begin
          exp_r = decoded_q.pop_front();
          if (exp_r != {status, event_kind, die_echo, event_value}) begin
            $display("%0t: mismatch s/k/e/v expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                     $time, exp_r.status, exp_r.kind, exp_r.echo, exp_r.value,
                     status, event_kind, die_echo, event_value);
            error_count <= error_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == opd_pkg::REG_PRESENT) present_reg <= cfg_data[0];
        else enable_reg <= cfg_data;
      end
    end
  end

endmodule

[dv/orientation_packet_decoder_tb.sv]
// ----------------------------------------------------------------------------
// orientation_packet_decoder_tb
// Drives directed and random die packets through the decoder across several
// register settings, with random gaps on both channels; the checker compares
// every result against its own decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orientation_packet_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [7:0] die_number = '0;
  logic [6:0] die_sides = '0;
  logic [7:0] packet_length = '0;
  logic [7:0] byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0, byte4 = '0;
  logic cfg_ready, in_stall, out_valid;
  logic [1:0] status;
  logic [2:0] event_kind;
  logic [7:0] die_echo;
  logic [6:0] event_value;
  int error_count, pending_count;
  int cycles = 0;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  orientation_packet_decoder dut (.*);
  orientation_packet_decoder_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_packet(input logic [7:0] len, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4,
                             input logic [6:0] sides);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    die_number <= 8'($urandom);
    die_sides <= sides;
    packet_length <= len;
    {byte0, byte1, byte2, byte3, byte4} <= {b0, b1, b2, b3, b4};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_sides();
    logic [6:0] s[7] = '{4, 6, 8, 10, 12, 20, 100};
    return ($urandom_range(9) == 0) ? 7'($urandom) : s[$urandom_range(6)];
  endfunction

  task automatic random_packet();
    logic [7:0] r[5];
    logic [7:0] len;
    int kind;
    foreach (r[i]) r[i] = 8'($urandom);
    kind = $urandom_range(11);
    len = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    case (kind)
      0: begin r[0] = "R"; end
      1: begin r[0:2] = '{"T", "a", "p"}; end
      2: begin r[0:3] = '{"D", "T", "a", "p"}; end
      3: begin
        r[0:2] = '{"B", "a", "t"};
        if ($urandom_range(3) != 0) begin len = 8'd4; r[3] = 8'($urandom_range(100)); end
      end
      4: begin
        r[0:3] = '{"C", "h", "a", "r"};
        if ($urandom_range(3) != 0) begin len = 8'd5; r[4] = 8'($urandom_range(1)); end
      end
      5, 6: begin r[0] = "S"; if ($urandom_range(4) != 0) len = 8'd4; end
      7, 8: begin
        r[0] = ($urandom_range(2) == 0) ? "F" : ($urandom_range(1) ? "T" : "M");
        r[1] = "S";
        if ($urandom_range(4) != 0) len = 8'd5;
      end
      9: begin
        r[0:2] = '{"C", "o", "l"};
        if ($urandom_range(3) != 0) begin len = 8'd4; r[3] = 8'($urandom_range(5)); end
      end
      default: ;
    endcase
    send_packet(len, r[0], r[1], r[2], r[3], r[4], pick_sides());
  endtask

  initial begin
    logic [4:0] enables[6] = '{5'h1f, 5'h00, 5'h15, 5'h0a, 5'h1f, 5'h1f};
    logic       presents[6] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: every prefix, extremes of the axis bytes and lengths
    send_packet(1, "R", 0, 0, 0, 0, 6);
    send_packet(3, "T", "a", "p", 0, 0, 6);
    send_packet(4, "D", "T", "a", "p", 0, 6);
    send_packet(4, "B", "a", "t", 100, 0, 6);
    send_packet(4, "B", "a", "t", 101, 0, 6);
    send_packet(5, "C", "h", "a", "r", 1, 6);
    send_packet(5, "C", "h", "a", "r", 2, 6);
    send_packet(4, "C", "o", "l", 5, 0, 6);
    send_packet(4, "C", "o", "l", 6, 0, 6);
    send_packet(4, "S", 8'h80, 8'h80, 8'h80, 0, 20);
    send_packet(4, "S", 8'h7f, 8'h7f, 8'h7f, 0, 4);
    send_packet(4, "S", 0, 0, 0, 0, 12);
    send_packet(5, "F", "S", 8'h80, 8'h7f, 8'h00, 100);
    send_packet(5, "T", "S", 8'hc0, 0, 0, 8);
    send_packet(5, "M", "S", 0, 64, 0, 10);
    send_packet(5, "M", "S", 0, 64, 0, 7);
    send_packet(4, "S", 0, 0, 0, 0, 127);
    send_packet(3, "S", 0, 0, 0, 0, 6);
    send_packet(2, "T", "a", "p", 0, 0, 6);
    send_packet(0, "R", 0, 0, 0, 0, 6);
    send_packet(255, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 0);
    send_packet(255, "R", 0, 0, 0, 0, 6);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(opd_pkg::REG_PRESENT, {4'b0, presents[ph]});
      write_reg(opd_pkg::REG_ENABLE, enables[ph]);
      calm = (ph == 5);
      repeat (ph == 0 ? 600 : 170) random_packet();
      calm = 1'b0;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/opd_pkg.sv
rtl/opd_classify.sv
rtl/opd_face.sv
rtl/orientation_packet_decoder.sv
dv/orientation_packet_decoder_checker.sv
dv/orientation_packet_decoder_tb.sv
